### rtl/clirs_pkg.sv
// Shared types, codes and constants for the circular list search block.
`timescale 1ns / 1ps
`default_nettype none

package clirs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W        = 32;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic tok;
        logic fnd;
    } chain_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

### rtl/clirs_cell.sv
// One list cell: holds an entry, compares it against the probe and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module clirs_cell
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [clirs_pkg::VAL_W-1:0] key,
    input  wire logic                     remove,
    input  wire logic                     ins,
    input  wire clirs_pkg::entry_t        prev_entry,
    input  wire clirs_pkg::entry_t        next_entry,
    input  wire clirs_pkg::chain_t        next_here,
    input  wire clirs_pkg::chain_t        chain_in,
    output clirs_pkg::chain_t             here,
    output clirs_pkg::chain_t             chain_out,
    output clirs_pkg::entry_t             entry
);

    clirs_pkg::chain_t             here_reg;
    logic                          valid_reg;
    logic                          valid_next;
    logic [clirs_pkg::VAL_W-1:0]   value_reg;
    logic [clirs_pkg::VAL_W-1:0]   value_next;
    logic                          match;
    logic                          pull;

    assign match = here_reg.tok & valid_reg & (value_reg == key) & ~here_reg.fnd;
    assign pull  = remove & next_here.tok & next_here.fnd;

    assign chain_out.tok = here_reg.tok;
    assign chain_out.fnd = here_reg.fnd | match;
    assign here          = here_reg;
    assign entry.valid   = valid_reg;
    assign entry.value   = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ins)
        begin
            valid_next = prev_entry.valid;
            value_next = prev_entry.value;
        end
        else if (pull)
        begin
            valid_next = next_entry.valid;
            value_next = next_entry.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            here_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            here_reg  <= chain_in;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### rtl/circular_list_insert_remove_search.sv
// Timing: insert and unused request kinds answer in the cycle after the beat is taken.
// Search and remove pass the probe through launch_reg, the cells' here registers and end_reg
// before the answer is registered. Throughput: one request at a time; the next beat is taken
// once the result beat has left.
// Reset: asynchronous, active low; list empty, count zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_insert_remove_search
#(
    parameter int CAPACITY = clirs_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((clirs_pkg::STATUS_W + CNT_W + 7) / 8) * 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [clirs_pkg::VAL_W-1:0]   s_tdata,  // item_value
    input  wire logic [clirs_pkg::REQ_W-1:0]   s_tuser,  // req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [OUT_W-1:0]                   m_tdata   // status, entry_total
);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                              state_reg;
    logic                                out_valid_reg;
    logic [clirs_pkg::STATUS_W-1:0]      out_status_reg;
    logic [CNT_W-1:0]                    out_total_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [clirs_pkg::VAL_W-1:0]         key_reg;
    logic                                remove_reg;
    logic                                launch_reg;
    clirs_pkg::chain_t                   end_reg;

    logic                                accept;
    logic                                full;
    logic                                ins;
    clirs_pkg::entry_t                   ins_entry;
    clirs_pkg::chain_t                   launch_chain;
    clirs_pkg::entry_t                   null_entry;

    clirs_pkg::chain_t                   here_arr [CAPACITY];
    clirs_pkg::chain_t                   fwd_arr  [CAPACITY];
    clirs_pkg::entry_t                   ent_arr  [CAPACITY];
    logic [CAPACITY-1:0]                 tok_vec;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign ins      = accept && (s_tuser == clirs_pkg::REQ_INSERT) && !full;

    assign ins_entry.valid    = 1'b1;
    assign ins_entry.value    = s_tdata;
    assign null_entry.valid   = 1'b0;
    assign null_entry.value   = '0;
    assign launch_chain.tok   = launch_reg;
    assign launch_chain.fnd   = 1'b0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_total_reg, out_status_reg});

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            clirs_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .key        (key_reg),
                .remove     (remove_reg),
                .ins        (ins),
                .prev_entry ((k == 0) ? ins_entry : ent_arr[(k == 0) ? 0 : k - 1]),
                .next_entry ((k == CAPACITY - 1) ? null_entry
                                                 : ent_arr[(k == CAPACITY - 1) ? k : k + 1]),
                .next_here  ((k == CAPACITY - 1) ? end_reg
                                                 : here_arr[(k == CAPACITY - 1) ? k : k + 1]),
                .chain_in   ((k == 0) ? launch_chain : fwd_arr[(k == 0) ? 0 : k - 1]),
                .here       (here_arr[k]),
                .chain_out  (fwd_arr[k]),
                .entry      (ent_arr[k])
            );
            assign tok_vec[k] = here_arr[k].tok;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= clirs_pkg::STAT_DONE;
            out_total_reg  <= '0;
            count_reg      <= '0;
            key_reg        <= '0;
            remove_reg     <= 1'b0;
            launch_reg     <= 1'b0;
            end_reg        <= '0;
        end
        else
        begin
            launch_reg <= 1'b0;
            end_reg    <= fwd_arr[CAPACITY-1];
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg <= s_tdata;
                        unique case (s_tuser)
                            clirs_pkg::REQ_INSERT:
                            begin
                                out_valid_reg <= 1'b1;
                                if (full)
                                begin
                                    out_status_reg <= clirs_pkg::STAT_FULL;
                                    out_total_reg  <= count_reg;
                                end
                                else
                                begin
                                    out_status_reg <= clirs_pkg::STAT_DONE;
                                    out_total_reg  <= count_reg + CNT_W'(1);
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                            end
                            clirs_pkg::REQ_REMOVE:
                            begin
                                remove_reg <= 1'b1;
                                launch_reg <= 1'b1;
                                state_reg  <= ST_WALK;
                            end
                            clirs_pkg::REQ_SEARCH:
                            begin
                                remove_reg <= 1'b0;
                                launch_reg <= 1'b1;
                                state_reg  <= ST_WALK;
                            end
                            default:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= clirs_pkg::STAT_NOT_FOUND;
                                out_total_reg  <= count_reg;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (end_reg.tok)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (end_reg.fnd)
                        begin
                            out_status_reg <= clirs_pkg::STAT_DONE;
                            if (remove_reg)
                            begin
                                count_reg     <= count_reg - CNT_W'(1);
                                out_total_reg <= count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_total_reg <= count_reg;
                            end
                        end
                        else
                        begin
                            out_status_reg <= clirs_pkg::STAT_NOT_FOUND;
                            out_total_reg  <= count_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({end_reg.tok, tok_vec, launch_reg}))
        else $error("more than one probe in the chain");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (tok_vec == '0) && !end_reg.tok)
        else $error("probe in flight while idle");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for the circular list block: directed table, then random request phases.
`timescale 1ns / 1ps

module tb_top;

    import clirs_pkg::*;

    localparam int              LIST_DEPTH = CAPACITY_DEF;
    localparam int              CNT_BITS   = $clog2(LIST_DEPTH + 1);
    localparam int              RES_BITS   = ((STATUS_W + CNT_BITS + 7) / 8) * 8;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int              RAND_ITEMS = 900;
    localparam int              PHASE_LEN  = 75;
    localparam int              TAIL_WAIT  = LIST_DEPTH + 16;
    localparam int              CYCLE_CAP  = 500000;
    localparam int              HOLD_LONG  = 400;
    localparam int              POOL_SIZE  = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_BITS-1:0] total;
    } answer_t;

    typedef struct {
        bit      typed;
        answer_t ans;
    } note_t;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [VAL_W-1:0]    value;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [CNT_BITS-1:0] total;
    } row_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VAL_W-1:0]    s_tdata  = '0;
    logic [REQ_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RES_BITS-1:0] m_tdata;

    logic [VAL_W-1:0] list_vals [$];
    answer_t          answers_due [$];
    note_t            notes_q [$];
    logic [VAL_W-1:0] pool [POOL_SIZE];

    int  errors    = 0;
    int  sent_n    = 0;
    int  done_n    = 0;
    int  cycle_cnt = 0;
    bit  idle_on   = 1'b1;
    bit  long_hold = 1'b0;

    row_t dir_rows [22] = '{
        '{REQ_SEARCH, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},
        '{REQ_REMOVE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},
        '{REQ_UNUSED, 32'h0000_0005, 1'b1, STAT_NOT_FOUND, 7'd0},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_DONE,      7'd1},
        '{REQ_INSERT, 32'h8000_0000, 1'b1, STAT_DONE,      7'd2},
        '{REQ_INSERT, 32'h0000_0000, 1'b1, STAT_DONE,      7'd3},
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_DONE,      7'd4},
        '{REQ_SEARCH, 32'h8000_0000, 1'b1, STAT_DONE,      7'd4},
        '{REQ_SEARCH, 32'h7FFF_FFFF, 1'b1, STAT_DONE,      7'd4},
        '{REQ_SEARCH, 32'h0000_0001, 1'b1, STAT_NOT_FOUND, 7'd4},
        '{REQ_UNUSED, 32'h7FFF_FFFF, 1'b1, STAT_NOT_FOUND, 7'd4},
        '{REQ_INSERT, 32'h0000_0000, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h0000_0000, 1'b0, STAT_DONE,      7'd0},
        '{REQ_SEARCH, 32'h0000_0000, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h0000_3039, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'hFFFF_FFFF, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h0000_0000, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h8000_0000, 1'b0, STAT_DONE,      7'd0},
        '{REQ_REMOVE, 32'h8000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},
        '{REQ_INSERT, 32'h0000_0037, 1'b1, STAT_DONE,      7'd1},
        '{REQ_SEARCH, 32'h0000_0037, 1'b1, STAT_DONE,      7'd1}
    };

    circular_list_insert_remove_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // item_value
        .s_tuser  (s_tuser),   // req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, entry_total
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic answer_t apply_request(input logic [REQ_W-1:0] kind,
                                              input logic [VAL_W-1:0] value);
        answer_t a;
        int      hit;
        hit = -1;
        a.status = STAT_NOT_FOUND;
        if (kind == REQ_REMOVE || kind == REQ_SEARCH)
        begin
            for (int i = 0; i < list_vals.size(); i++)
            begin
                if (hit < 0 && list_vals[i] == value)
                    hit = i;
            end
        end
        if (kind == REQ_INSERT)
        begin
            if (list_vals.size() >= LIST_DEPTH)
                a.status = STAT_FULL;
            else
            begin
                list_vals.push_front(value);
                a.status = STAT_DONE;
            end
        end
        else if (kind == REQ_REMOVE && hit >= 0)
        begin
            list_vals.delete(hit);
            a.status = STAT_DONE;
        end
        else if (kind == REQ_SEARCH && hit >= 0)
            a.status = STAT_DONE;
        a.total = CNT_BITS'(list_vals.size());
        return a;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] value,
                            input bit typed, input answer_t ans);
        note_t n;
        n.typed = typed;
        n.ans   = ans;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        notes_q.push_back(n);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sent_n++;
    endtask

    // track accepted requests and check result beats
    always @(posedge clk)
    begin
        note_t   n;
        answer_t pred;
        answer_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                n    = notes_q.pop_front();
                pred = apply_request(s_tuser, s_tdata);
                answers_due.push_back(n.typed ? n.ans : pred);
            end
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat status=%0d total=%0d",
                             $time, m_tdata[1:0], m_tdata[CNT_BITS+1:2]);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[1:0]);
                    end
                    if (m_tdata[CNT_BITS+1:2] !== want.total)
                    begin
                        errors++;
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, want.total, m_tdata[CNT_BITS+1:2]);
                    end
                end
                done_n++;
            end
        end
    end

    initial
    begin
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LONG) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        answer_t          none;
        int               mode;
        int               pick;
        int               pool_pct;
        logic [REQ_W-1:0] kind;
        logic [VAL_W-1:0] value;

        none = '0;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed,
                     '{status: dir_rows[i].status, total: dir_rows[i].total});

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                mode    = (i / PHASE_LEN) % 4;
                idle_on = (i < RAND_ITEMS - 2 * PHASE_LEN) && ($urandom_range(0, 3) != 0);
                if (i / PHASE_LEN == 2)
                    long_hold = 1'b1;
                if (i / PHASE_LEN == 5)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (done_n != sent_n)
                        @(posedge clk);
                end
            end
            pick = $urandom_range(0, 99);
            case (mode)
                0:
                begin
                    kind     = (pick < 85) ? REQ_INSERT : (pick < 93) ? REQ_SEARCH :
                               (pick < 98) ? REQ_REMOVE : REQ_UNUSED;
                    pool_pct = 75;
                end
                2:
                begin
                    kind     = (pick < 70) ? REQ_REMOVE : (pick < 90) ? REQ_SEARCH :
                               (pick < 98) ? REQ_INSERT : REQ_UNUSED;
                    pool_pct = 95;
                end
                default:
                begin
                    kind     = (pick < 40) ? REQ_INSERT : (pick < 70) ? REQ_REMOVE :
                               (pick < 96) ? REQ_SEARCH : REQ_UNUSED;
                    pool_pct = 80;
                end
            endcase
            value = ($urandom_range(0, 99) < pool_pct) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                                       : $urandom;
            send_req(kind, value, 1'b0, none);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (done_n != sent_n)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, answers_due.size());
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
